FILE: hdl/rlkq_pkg.sv
// ----------------------------------------------------------------------------
// rlkq_pkg
// shared widths, window table, key codes and result type for the ladder key
// qualifier
// ----------------------------------------------------------------------------
package rlkq_pkg;

  localparam int SAMPLE_W      = 12;
  localparam int TIME_W        = 32;
  localparam int KEY_W         = 3;
  localparam int CNT_W         = 3;
  localparam int HOLD_W        = 16;
  localparam int LIGHT_W       = 5;
  localparam int CFG_DATA_W    = 32;
  localparam int CFG_ADDR_W    = 3;

  localparam int TABLE_WINDOWS   = 6;
  localparam int NUM_WINDOWS_DEF = 6;

  localparam logic [KEY_W-1:0] KEY_RELEASED   = 3'd0;
  localparam logic [KEY_W-1:0] KEY_FIRST      = 3'd1;
  localparam logic [KEY_W-1:0] KEY_LAST_LIGHT = 3'd5;
  localparam logic [KEY_W-1:0] KEY_SYSTEM     = 3'd6;

  localparam logic [CNT_W-1:0]  CONFIRM_RST = 3'd4;
  localparam logic [HOLD_W-1:0] HOLD_RST    = 16'd3000;

  localparam logic REG_CONFIRM = 1'b0;
  localparam logic REG_HOLD    = 1'b1;

  localparam logic [SAMPLE_W-1:0] WIN_LOW [TABLE_WINDOWS] =
    '{12'd160, 12'd640, 12'd1220, 12'd1870, 12'd2440, 12'd2960};
  localparam logic [SAMPLE_W-1:0] WIN_HIGH [TABLE_WINDOWS] =
    '{12'd380, 12'd850, 12'd1470, 12'd2120, 12'd2790, 12'd3260};

  typedef struct packed {
    logic [KEY_W-1:0]   key_state;
    logic               press_valid;
    logic [KEY_W-1:0]   press_key;
    logic               release_valid;
    logic [KEY_W-1:0]   release_key;
    logic               join_req;
    logic               wipe_req;
    logic [LIGHT_W-1:0] light_mask;
  } result_t;

endpackage

FILE: hdl/resistor_ladder_key_qualifier.sv
// ----------------------------------------------------------------------------
// resistor_ladder_key_qualifier
// ladder keypad debounce with press/release events, system key hold timing
// and per-key light mask
// registered path: input register, then result register, from input beat to result beat
// throughput: one poll per cycle while out_stall is low, set by the single-pass update of the key state
// reset: synchronous active-low; clears key state, hold timer and light mask,
//   loads confirm_polls 4 and hold_ms 3000, empties both beat registers
// ----------------------------------------------------------------------------
module resistor_ladder_key_qualifier
  import rlkq_pkg::*;
#(
  parameter int NUM_WINDOWS = NUM_WINDOWS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready,

  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [SAMPLE_W-1:0]   in_adc_sample,
  input  logic [TIME_W-1:0]     in_now_ms,
  input  logic                  in_link_ready,

  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [KEY_W-1:0]      out_key_state,
  output logic                  out_press_valid,
  output logic [KEY_W-1:0]      out_press_key,
  output logic                  out_release_valid,
  output logic [KEY_W-1:0]      out_release_key,
  output logic                  out_join_req,
  output logic                  out_wipe_req,
  output logic [LIGHT_W-1:0]    out_light_mask
);

  logic [CNT_W-1:0]    confirm_polls_r;
  logic [HOLD_W-1:0]   hold_ms_r;

  logic                in_valid_r;
  logic [SAMPLE_W-1:0] sample_r;
  logic [TIME_W-1:0]   now_r;
  logic                link_r;

  logic                out_valid_r;
  result_t             res_r;
  result_t             res_nxt;

  logic                cfg_wr;
  logic                advance;
  logic                in_accept;
  logic [KEY_W-1:0]    raw_key;

  // configuration registers
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      confirm_polls_r <= CONFIRM_RST;
      hold_ms_r       <= HOLD_RST;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        REG_CONFIRM: confirm_polls_r <= cfg_pwdata[CNT_W-1:0];
        REG_HOLD:    hold_ms_r       <= cfg_pwdata[HOLD_W-1:0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      REG_CONFIRM: cfg_prdata = CFG_DATA_W'(confirm_polls_r);
      REG_HOLD:    cfg_prdata = CFG_DATA_W'(hold_ms_r);
      default:     cfg_prdata = '0;
    endcase
  end

  // beat handshake
  assign advance   = !out_valid_r || !out_stall;
  assign in_stall  = in_valid_r && !advance;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_accept) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      sample_r <= in_adc_sample;
      now_r    <= in_now_ms;
      link_r   <= in_link_ready;
    end
  end

  rlkq_classify #(
    .NUM_WINDOWS(NUM_WINDOWS)
  ) u_classify (
    .sample  (sample_r),
    .raw_key (raw_key)
  );

  rlkq_track u_track (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (in_valid_r && advance),
    .raw_key       (raw_key),
    .now_ms        (now_r),
    .link_ready    (link_r),
    .confirm_polls (confirm_polls_r),
    .hold_ms       (hold_ms_r),
    .result        (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid_r) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_key_state     = res_r.key_state;
  assign out_press_valid   = res_r.press_valid;
  assign out_press_key     = res_r.press_key;
  assign out_release_valid = res_r.release_valid;
  assign out_release_key   = res_r.release_key;
  assign out_join_req      = res_r.join_req;
  assign out_wipe_req      = res_r.wipe_req;
  assign out_light_mask    = res_r.light_mask;

  // result consistency
  a_fr_on_system: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.wipe_req |-> res_r.key_state == KEY_SYSTEM)
    else $error("wipe request without system key");

  a_pj_on_release: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.join_req |-> res_r.key_state == KEY_RELEASED)
    else $error("join request while a key is held");

  a_press_key: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.press_valid |->
      (res_r.key_state == res_r.press_key + KEY_FIRST) && !res_r.release_valid)
    else $error("press event does not match key state");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> in_valid_r && out_valid_r)
    else $error("input stalled with room in the pipeline");

endmodule

FILE: hdl/rlkq_classify.sv
// ----------------------------------------------------------------------------
// rlkq_classify
// sorts a ladder sample into the first matching voltage window, 0 if none
// ----------------------------------------------------------------------------
module rlkq_classify
  import rlkq_pkg::*;
#(
  parameter int NUM_WINDOWS = NUM_WINDOWS_DEF
) (
  input  logic [SAMPLE_W-1:0] sample,
  output logic [KEY_W-1:0]    raw_key
);

  localparam int EFF_WINDOWS = (NUM_WINDOWS > TABLE_WINDOWS) ? TABLE_WINDOWS : NUM_WINDOWS;

  // lowest matching window wins
  always_comb begin
    raw_key = KEY_RELEASED;
    for (int i = EFF_WINDOWS - 1; i >= 0; i--) begin
      if (sample >= WIN_LOW[i] && sample <= WIN_HIGH[i]) begin
        raw_key = KEY_W'(i + 1);
      end
    end
  end

endmodule

FILE: hdl/rlkq_track.sv
// ----------------------------------------------------------------------------
// rlkq_track
// debounce state, press/release events, system key hold timing and light mask
// ----------------------------------------------------------------------------
module rlkq_track
  import rlkq_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic [KEY_W-1:0]    raw_key,
  input  logic [TIME_W-1:0]   now_ms,
  input  logic                link_ready,
  input  logic [CNT_W-1:0]    confirm_polls,
  input  logic [HOLD_W-1:0]   hold_ms,
  output result_t             result
);

  logic [KEY_W-1:0]   cand_key_r;
  logic [CNT_W-1:0]   cand_run_r, cand_run_nxt;
  logic [KEY_W-1:0]   conf_key_r, conf_key_nxt;
  logic               sys_held_r, sys_held_nxt;
  logic [TIME_W-1:0]  hold_start_r, hold_start_nxt;
  logic [LIGHT_W-1:0] light_r, light_nxt;

  logic               confirm;
  logic               press;
  logic               release_ev;
  logic               sys_up;
  logic               sys_active;
  logic               elapsed_ge;
  logic [TIME_W-1:0]  elapsed;
  logic [KEY_W-1:0]   press_idx;
  logic [KEY_W-1:0]   release_idx;

  always_comb begin
    if (raw_key == cand_key_r) begin
      cand_run_nxt = (cand_run_r < confirm_polls) ? cand_run_r + CNT_W'(1) : cand_run_r;
    end else begin
      cand_run_nxt = CNT_W'(1);
    end

    confirm      = (cand_run_nxt >= confirm_polls) && (raw_key != conf_key_r);
    conf_key_nxt = confirm ? raw_key : conf_key_r;

    press      = confirm && (conf_key_r == KEY_RELEASED) &&
                 (raw_key >= KEY_FIRST) && (raw_key <= KEY_LAST_LIGHT);
    release_ev = confirm && (conf_key_r >= KEY_FIRST) && (conf_key_r <= KEY_LAST_LIGHT);
    press_idx   = raw_key - KEY_FIRST;
    release_idx = conf_key_r - KEY_FIRST;

    elapsed    = now_ms - hold_start_r;
    elapsed_ge = elapsed >= TIME_W'(hold_ms);

    // hold check on any poll that ends on the system key
    sys_active     = (conf_key_nxt == KEY_SYSTEM);
    sys_up         = confirm && (conf_key_r == KEY_SYSTEM) && (raw_key == KEY_RELEASED);
    hold_start_nxt = (sys_active && !sys_held_r) ? now_ms : hold_start_r;
    if (sys_active) begin
      sys_held_nxt = 1'b1;
    end else if (sys_up) begin
      sys_held_nxt = 1'b0;
    end else begin
      sys_held_nxt = sys_held_r;
    end

    light_nxt = light_r;
    if (link_ready && press) begin
      light_nxt = light_nxt | (LIGHT_W'(1) << press_idx);
    end
    if (link_ready && release_ev) begin
      light_nxt = light_nxt & ~(LIGHT_W'(1) << release_idx);
    end

    result.key_state     = conf_key_nxt;
    result.press_valid   = press;
    result.press_key     = press ? press_idx : KEY_RELEASED;
    result.release_valid = release_ev;
    result.release_key   = release_ev ? release_idx : KEY_RELEASED;
    result.join_req      = sys_up && sys_held_r && !elapsed_ge;
    // only an entry from released checks the fresh hold twice
    result.wipe_req      = sys_active &&
                           (sys_held_r ? elapsed_ge :
                            ((hold_ms == '0) && (conf_key_r == KEY_RELEASED)));
    result.light_mask    = light_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cand_key_r   <= KEY_RELEASED;
      cand_run_r   <= '0;
      conf_key_r   <= KEY_RELEASED;
      sys_held_r   <= 1'b0;
      hold_start_r <= '0;
      light_r      <= '0;
    end else if (step) begin
      cand_key_r   <= raw_key;
      cand_run_r   <= cand_run_nxt;
      conf_key_r   <= conf_key_nxt;
      sys_held_r   <= sys_held_nxt;
      hold_start_r <= hold_start_nxt;
      light_r      <= light_nxt;
    end
  end

endmodule
